// File: rtl/core/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    localparam int PAGE_BITS_DEF   = 12;
    localparam int REGION_BITS_DEF = 20;
    localparam int ORD_W           = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [20:0] request_size;
        logic [19:0] block_offset;
    } t_in;

    typedef struct packed {
        logic [19:0] result_offset;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic             head;
        logic             free;
        logic [ORD_W-1:0] order;
    } t_rec;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR,
        DP_RD_P,
        DP_RD_B,
        DP_SCAN_NEXT,
        DP_ORDER_NEXT,
        DP_SPLIT,
        DP_WR_ALLOC,
        DP_INIT_O,
        DP_MERGE_B,
        DP_MERGE_P,
        DP_WR_FREE,
        DP_FAIL_SPACE,
        DP_FAIL_FREE,
        DP_PUSH
    } t_dp_op;

    typedef struct packed {
        logic op;
        logic too_big;
        logic free_bad;
        logic rec_match;
        logic rec_alloc;
        logic scan_end;
        logic j_top;
        logic split_done;
        logic clr_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: rtl/core/bpa_ram.sv
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bpa_datapath.sv
`default_nettype none
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int REGION_BITS = REGION_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_op   i_cmd,
    input  wire t_in      i_in,
    output t_dp_stat      o_stat,
    output t_out          o_out
);

    localparam int ORDER_TOP  = REGION_BITS - PAGE_BITS;
    localparam int PG_W       = ORDER_TOP;
    localparam int PAGE_COUNT = 1 << PG_W;
    localparam int J_W        = $clog2(ORDER_TOP + 1);

    logic [PG_W-1:0] r_p, n_p;
    logic [J_W-1:0]  r_j, n_j;
    logic [J_W-1:0]  r_want, n_want;
    logic            r_op, n_op;
    logic            r_too_big, n_too_big;
    logic            r_free_bad, n_free_bad;
    t_out            r_res, n_res;
    t_out            r_out, n_out;

    logic            wr_en;
    logic [PG_W-1:0] wr_addr;
    t_rec            wr_data;
    logic            rd_en;
    logic [PG_W-1:0] rd_addr;
    logic [5:0]      rd_raw;
    t_rec            rec;

    logic [J_W-1:0]  calc_want;
    logic            calc_big;
    logic [32:0]     calc_pg;
    logic            calc_bad;
    logic [PG_W-1:0] bit_j;
    logic [PG_W-1:0] bit_jm1;
    logic [J_W-1:0]  j_m1;

    assign rec     = t_rec'(rd_raw);
    assign j_m1    = r_j - J_W'(1);
    assign bit_j   = PG_W'(1) << r_j;
    assign bit_jm1 = PG_W'(1) << j_m1;

    always_comb begin
        calc_want = J_W'(ORDER_TOP);
        for (int w = ORDER_TOP; w >= 0; w--) begin
            if (64'(i_in.request_size) <= (64'(1) << (PAGE_BITS + w))) begin
                calc_want = J_W'(w);
            end
        end
        calc_big = 64'(i_in.request_size) > (64'(1) << (PAGE_BITS + ORDER_TOP));
        calc_pg  = 33'(i_in.block_offset) >> PAGE_BITS;
        calc_bad = ((64'(i_in.block_offset) & ((64'(1) << PAGE_BITS) - 64'(1))) != 64'(0))
                   || (calc_pg >= 33'(PAGE_COUNT));
    end

    always_comb begin
        n_p        = r_p;
        n_j        = r_j;
        n_want     = r_want;
        n_op       = r_op;
        n_too_big  = r_too_big;
        n_free_bad = r_free_bad;
        n_res      = r_res;
        n_out      = r_out;
        wr_en      = 1'b0;
        wr_addr    = r_p;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = r_p;
        case (i_cmd)
            DP_LOAD: begin
                n_op       = i_in.op;
                n_want     = calc_want;
                n_too_big  = calc_big;
                n_free_bad = calc_bad;
                if (i_in.op == OP_ALLOC) begin
                    n_p = '0;
                    n_j = calc_want;
                end else begin
                    n_p = PG_W'(calc_pg);
                end
            end
            DP_CLR: begin
                wr_en = 1'b1;
                if (r_p == '0) begin
                    wr_data = '{head: 1'b1, free: 1'b1, order: ORD_W'(ORDER_TOP)};
                end
                n_p = r_p + PG_W'(1);
            end
            DP_RD_P: begin
                rd_en = 1'b1;
            end
            DP_RD_B: begin
                rd_en   = 1'b1;
                rd_addr = r_p ^ bit_j;
            end
            DP_SCAN_NEXT: begin
                n_p = r_p + bit_j;
            end
            DP_ORDER_NEXT: begin
                n_p = '0;
                n_j = r_j + J_W'(1);
            end
            DP_SPLIT: begin
                wr_en   = 1'b1;
                wr_addr = r_p | bit_jm1;
                wr_data = '{head: 1'b1, free: 1'b1, order: ORD_W'(j_m1)};
                n_j     = j_m1;
            end
            DP_WR_ALLOC: begin
                wr_en   = 1'b1;
                wr_data = '{head: 1'b1, free: 1'b0, order: ORD_W'(r_want)};
                n_res   = '{result_offset: 20'(64'(r_p) << PAGE_BITS), status: ST_OK};
            end
            DP_INIT_O: begin
                if (32'(rec.order) > 32'(ORDER_TOP)) begin
                    n_j = J_W'(ORDER_TOP);
                end else begin
                    n_j = J_W'(rec.order);
                end
            end
            DP_MERGE_B: begin
                wr_en   = 1'b1;
                wr_addr = r_p ^ bit_j;
            end
            DP_MERGE_P: begin
                wr_en = 1'b1;
                n_p   = r_p & ~bit_j;
                n_j   = r_j + J_W'(1);
            end
            DP_WR_FREE: begin
                wr_en   = 1'b1;
                wr_data = '{head: 1'b1, free: 1'b1, order: ORD_W'(r_j)};
                n_res   = '{result_offset: '0, status: ST_OK};
            end
            DP_FAIL_SPACE: begin
                n_res = '{result_offset: '0, status: ST_NO_SPACE};
            end
            DP_FAIL_FREE: begin
                n_res = '{result_offset: '0, status: ST_BAD_FREE};
            end
            DP_PUSH: begin
                n_out = r_res;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_j <= '0;
        end else begin
            r_p <= n_p;
            r_j <= n_j;
        end
        r_want     <= n_want;
        r_op       <= n_op;
        r_too_big  <= n_too_big;
        r_free_bad <= n_free_bad;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    bpa_ram #(
        .WIDTH (6),
        .DEPTH (PAGE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    always_comb begin
        o_stat.op         = r_op;
        o_stat.too_big    = r_too_big;
        o_stat.free_bad   = r_free_bad;
        o_stat.rec_match  = rec.head && rec.free && (rec.order == ORD_W'(r_j));
        o_stat.rec_alloc  = rec.head && !rec.free;
        o_stat.scan_end   = ({1'b0, r_p} + ((PG_W + 1)'(1) << r_j))
                            >= ((PG_W + 1)'(1) << PG_W);
        o_stat.j_top      = r_j == J_W'(ORDER_TOP);
        o_stat.split_done = r_j == r_want;
        o_stat.clr_done   = r_p == PG_W'(PAGE_COUNT - 1);
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// File: rtl/core/bpa_controller.sv
`default_nettype none
module bpa_controller
    import bpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_op        o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_RD,
        S_A_CHK,
        S_A_SPLIT,
        S_F_CHK,
        S_F_LOOP,
        S_F_BCHK,
        S_F_MERGE,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = DP_NOP;
        case (r_state)
            S_CLEAR: begin
                o_cmd = DP_CLR;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op == OP_ALLOC) begin
                    if (i_stat.too_big) begin
                        o_cmd   = DP_FAIL_SPACE;
                        n_state = S_FIN;
                    end else begin
                        o_cmd   = DP_RD_P;
                        n_state = S_A_CHK;
                    end
                end else if (i_stat.free_bad) begin
                    o_cmd   = DP_FAIL_FREE;
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_P;
                    n_state = S_F_CHK;
                end
            end
            S_A_RD: begin
                o_cmd   = DP_RD_P;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_stat.rec_match) begin
                    n_state = S_A_SPLIT;
                end else if (!i_stat.scan_end) begin
                    o_cmd   = DP_SCAN_NEXT;
                    n_state = S_A_RD;
                end else if (!i_stat.j_top) begin
                    o_cmd   = DP_ORDER_NEXT;
                    n_state = S_A_RD;
                end else begin
                    o_cmd   = DP_FAIL_SPACE;
                    n_state = S_FIN;
                end
            end
            S_A_SPLIT: begin
                if (i_stat.split_done) begin
                    o_cmd   = DP_WR_ALLOC;
                    n_state = S_FIN;
                end else begin
                    o_cmd = DP_SPLIT;
                end
            end
            S_F_CHK: begin
                if (i_stat.rec_alloc) begin
                    o_cmd   = DP_INIT_O;
                    n_state = S_F_LOOP;
                end else begin
                    o_cmd   = DP_FAIL_FREE;
                    n_state = S_FIN;
                end
            end
            S_F_LOOP: begin
                if (i_stat.j_top) begin
                    o_cmd   = DP_WR_FREE;
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_B;
                    n_state = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                if (i_stat.rec_match) begin
                    o_cmd   = DP_MERGE_B;
                    n_state = S_F_MERGE;
                end else begin
                    o_cmd   = DP_WR_FREE;
                    n_state = S_FIN;
                end
            end
            S_F_MERGE: begin
                o_cmd   = DP_MERGE_P;
                n_state = S_F_LOOP;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = DP_PUSH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/core/buddy_page_allocator.sv
// An allocate scans the page records of each order tried, then splits the found block
// once per level down to the wanted order and writes the allocated record; a free checks
// the record, then merges with its free buddy per level. One request is in work at a time.
// The page-record memory has one read port and one write port; the scan reads one record at a time.
// After reset a clearing pass over the 2^(REGION_BITS-PAGE_BITS) page records (256 by default)
// initializes them; no request is accepted during it.
`default_nettype none
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int REGION_BITS = REGION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    t_dp_op   cmd;
    t_dp_stat stat;

    bpa_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bpa_datapath #(
        .PAGE_BITS   (PAGE_BITS),
        .REGION_BITS (REGION_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/core/bpa_checker.sv
`default_nettype none
module bpa_checker
    import bpa_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire t_in  i_in,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not quiet after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status != 2'd3)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.result_offset == '0)
        else $error("failed request returned an offset");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in work");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
